@@ rtl/hkbi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkbi_pkg - shared types and constants for the hash key bucket index block
// Job format between front end and back end, mode codes, mixer constants.
// ----------------------------------------------------------------------------
package hkbi_pkg;

    localparam int KEY_W   = 32;
    localparam int HASH_W  = 32;
    localparam int LEN_W   = 31;
    localparam int MODE_W  = 2;
    localparam int CFG_A_W = 1;

    localparam logic [MODE_W-1:0] MODE_STRING = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FOLD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INT    = 2'd2;

    localparam logic [CFG_A_W-1:0] CFG_IDX_MODE = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_IDX_LEN  = 1'd1;

    localparam logic [LEN_W-1:0]  TABLE_LEN_RESET = 31'd53;
    localparam logic [HASH_W-1:0] INT_MIX_MUL     = 32'h045d_9f3b;

    // lower-case fold, per byte lane
    localparam logic [7:0] FOLD_MASK = 8'h7f;
    localparam logic [7:0] FOLD_ADD1 = 8'h25;
    localparam logic [7:0] FOLD_ADD2 = 8'h1a;
    localparam logic [7:0] FOLD_BIT  = 8'h20;

    typedef struct packed {
        logic              is_int;
        logic [HASH_W-1:0] raw;
    } t_job;

    function automatic logic [7:0] fold_lower(input logic [7:0] x);
        logic [7:0] t;
        t = (FOLD_MASK & x) + FOLD_ADD1;
        t = (FOLD_MASK & t) + FOLD_ADD2;
        t = ((t & ~x) >> 2) & FOLD_BIT;
        return x + t;
    endfunction

    function automatic logic [HASH_W-1:0] xorshift16(input logic [HASH_W-1:0] x);
        return (x >> 16) ^ x;
    endfunction

endpackage

@@ rtl/hkbi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkbi_front - key intake
// Takes one item per cycle unless stalled, runs the sdbm string accumulator
// and hands finished string hashes or raw integer keys to the job queue.
// ----------------------------------------------------------------------------
module hkbi_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [hkbi_pkg::MODE_W-1:0] i_hash_mode,
    input  logic                      i_accept,
    input  logic [hkbi_pkg::KEY_W-1:0] i_key_data,
    input  logic                      i_key_last,
    output logic                      o_push,
    output hkbi_pkg::t_job            o_job
);
    import hkbi_pkg::*;

    logic [HASH_W-1:0] r_acc, n_acc;
    logic              r_term, n_term;
    logic [7:0]        w_c;
    logic [HASH_W-1:0] w_sdbm;
    logic              w_int;

    assign w_int  = (i_hash_mode == MODE_INT);
    assign w_c    = (i_hash_mode == MODE_FOLD) ? fold_lower(i_key_data[7:0])
                                               : i_key_data[7:0];
    assign w_sdbm = {24'd0, w_c} + (r_acc << 6) + (r_acc << 16) - r_acc;

    always_comb begin
        n_acc  = r_acc;
        n_term = r_term;
        if (i_accept && !w_int && !r_term) begin
            if (w_c == 8'd0) begin
                n_term = 1'b1;
            end else begin
                n_acc = w_sdbm;
            end
        end
    end

    assign o_push       = i_accept && (w_int || i_key_last);
    assign o_job.is_int = w_int;
    assign o_job.raw    = w_int ? i_key_data : n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_term <= 1'b0;
        end else if (i_accept && !w_int && i_key_last) begin
            r_acc  <= '0;
            r_term <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_term <= n_term;
        end
    end

endmodule

@@ rtl/hkbi_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkbi_queue - job queue
// Small FIFO between the intake and the mixing / modulo engine.
// ----------------------------------------------------------------------------
module hkbi_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hkbi_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output hkbi_pkg::t_job o_job,
    input  logic           i_pop
);
    import hkbi_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_job     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/hkbi_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkbi_back - mixing and modulo engine
// Integer mix (two registered multiplies), supplemental mixer in two steps,
// then a one-bit-per-cycle restoring remainder against the table length.
// ----------------------------------------------------------------------------
module hkbi_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [hkbi_pkg::LEN_W-1:0]  i_table_length,
    input  logic                        i_job_valid,
    input  hkbi_pkg::t_job              i_job,
    output logic                        o_job_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hkbi_pkg::HASH_W-1:0] o_hash_value,
    output logic [hkbi_pkg::LEN_W-1:0]  o_bucket_index
);
    import hkbi_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MIX1  = 3'd1;
    localparam logic [2:0] ST_MIX2  = 3'd2;
    localparam logic [2:0] ST_SUPP1 = 3'd3;
    localparam logic [2:0] ST_SUPP2 = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_HOLD  = 3'd6;

    logic [2:0]        r_state;
    logic              r_is_int;
    logic [HASH_W-1:0] r_x;
    logic [HASH_W-1:0] r_hash;
    logic [LEN_W-1:0]  r_rem;
    logic [4:0]        r_cnt;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_hash;
    logic [LEN_W-1:0]  r_out_idx;

    logic [HASH_W-1:0] w_mul;
    logic [HASH_W-1:0] w_s_in, w_s1a, w_s1b, w_s2a, w_s2b;
    logic [HASH_W-1:0] w_rem_sh;
    logic              w_ge;
    logic              w_load_out;

    assign w_mul = xorshift16(r_x) * INT_MIX_MUL;

    // int keys still owe the final xorshift of the integer mix
    assign w_s_in = r_is_int ? xorshift16(r_x) : r_x;
    assign w_s1a  = w_s_in + ~(w_s_in << 9);
    assign w_s1b  = w_s1a ^ ((w_s1a >> 14) | (w_s1a << 18));
    assign w_s2a  = r_x + (r_x << 4);
    assign w_s2b  = w_s2a ^ ((w_s2a >> 10) | (w_s2a << 22));

    assign w_rem_sh = {r_rem, r_x[HASH_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, i_table_length});

    assign o_job_pop  = (r_state == ST_IDLE) && i_job_valid;
    assign w_load_out = (r_state == ST_HOLD) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= i_job.is_int ? ST_MIX1 : ST_SUPP1;
                    end
                end
                ST_MIX1:  r_state <= ST_MIX2;
                ST_MIX2:  r_state <= ST_SUPP1;
                ST_SUPP1: r_state <= ST_SUPP2;
                ST_SUPP2: begin
                    r_state <= ST_DIV;
                    r_cnt   <= '0;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x      <= i_job.raw;
                r_is_int <= i_job.is_int;
            end
            ST_MIX1, ST_MIX2: r_x <= w_mul;
            ST_SUPP1: r_x <= w_s1b;
            ST_SUPP2: begin
                r_x    <= w_s2b;
                r_hash <= w_s2b;
                r_rem  <= '0;
            end
            ST_DIV: begin
                r_x   <= r_x << 1;
                r_rem <= w_ge ? LEN_W'(w_rem_sh - {1'b0, i_table_length})
                              : w_rem_sh[LEN_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_hash <= r_hash;
            r_out_idx  <= (i_table_length == '0) ? '0 : r_rem;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hash_value   = r_out_hash;
    assign o_bucket_index = r_out_idx;

endmodule

@@ rtl/hash_key_bucket_index_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_key_bucket_index_top - hash-table key bucket index
// Hashes string or integer keys and reduces the hash to a bucket index.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per key byte (low 8 bits of tdata, tlast on the
//   final byte) in string modes, or one whole 32-bit key per item in integer
//   mode. A zero byte ends the key content; an empty key is a zero byte with
//   tlast. Master stream: one result item per finished key.
//   Configuration (hash_mode, table_length) is written through the plain write
//   port by the user only while the block is idle; the block does not check it.
//   Throughput: the intake takes one item per cycle as long as the job queue
//   has room. Each finished key then occupies the engine, which takes no new
//   key until it is done: two multiply steps (integer keys only), two mixer
//   steps, and a 32-step one-bit-per-cycle remainder, plus hand-off to the
//   output register.
//   Receiver stall: the result waits in the output register while the queue
//   keeps absorbing keys; the intake stalls only when the queue is full.
//   Reset: synchronous, active low; clears the accumulator, queue and output
//   valid, and restores hash_mode 0 and table_length 53.
// ----------------------------------------------------------------------------
module hash_key_bucket_index_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [30:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] key_data
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [31:0] hash_value, [62:32] bucket_index
);
    import hkbi_pkg::*;

    logic [MODE_W-1:0] r_hash_mode;
    logic [LEN_W-1:0]  r_table_length;
    logic              w_accept, w_push, w_full, w_qvalid, w_pop;
    t_job              w_push_job, w_q_job;
    logic [HASH_W-1:0] w_hash;
    logic [LEN_W-1:0]  w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mode    <= MODE_STRING;
            r_table_length <= TABLE_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IDX_MODE: r_hash_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_IDX_LEN:  r_table_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = !w_full;
    assign w_accept        = i_s_axis_tvalid && !w_full;

    hkbi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hash_mode (r_hash_mode),
        .i_accept    (w_accept),
        .i_key_data  (i_s_axis_tdata),
        .i_key_last  (i_s_axis_tlast),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    hkbi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_job   (w_q_job),
        .i_pop   (w_pop)
    );

    hkbi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_table_length (r_table_length),
        .i_job_valid    (w_qvalid),
        .i_job          (w_q_job),
        .o_job_pop      (w_pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_hash_value   (w_hash),
        .o_bucket_index (w_idx)
    );

    assign o_m_axis_tdata = {1'b0, w_idx, w_hash};

endmodule
